/* sv/sle_pkg.sv */
package sle_pkg;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_NORMAL  = 4'd1,
        M_ESC     = 4'd2,
        M_EOL     = 4'd3,
        M_HEX1    = 4'd4,
        M_HEX2    = 4'd5,
        M_UBRACE  = 4'd6,
        M_UFIRST  = 4'd7,
        M_UDIGITS = 4'd8,
        M_ZSKIP   = 4'd9,
        M_DEC     = 4'd10
    } mode_t;

    typedef enum logic [1:0] {
        K_DATA       = 2'd0,
        K_END        = 2'd1,
        K_BADESC     = 2'd2,
        K_UNFINISHED = 2'd3
    } kind_t;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LF_F  = 8'h66;
    localparam logic [7:0] CH_LN    = 8'h6e;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LT    = 8'h74;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_LV    = 8'h76;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7a;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [20:0] UNI_LIMIT = 21'h110000;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       last;
    } out_item_t;

    // results of one input item, val/knd[0] first
    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] val;
        logic [3:0][1:0] knd;
    } grp_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic grp_t grp_put(grp_t g, logic [7:0] b, kind_t k);
        grp_t r;
        r = g;
        if (g.cnt < 3'd4)
        begin
            r.val[g.cnt[1:0]] = b;
            r.knd[g.cnt[1:0]] = k;
            r.cnt = g.cnt + 3'd1;
        end
        return r;
    endfunction

    // {ok, value}
    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    function automatic logic is_eol(logic [7:0] c);
        return (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT)
            || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

/* sv/string_literal_escape_decoder.sv */
// Each accepted item's results are written to the group queue, then loaded into the output register.
// Throughput: one input item per cycle while the queue is not full; results leave one per
// cycle unless out_ready stalls them, one result at a time (4-deep group queue).
// Reset: asynchronous, active low; decoder idle awaiting a delimiter,
// delimiter and escape state cleared, queue and output register empty.
module string_literal_escape_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sle_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sle_pkg::out_item_t out_data
);

    sle_pkg::grp_t    push_grp;
    sle_pkg::grp_t    head;
    sle_pkg::q_stat_t q_stat;
    logic             push;
    logic             pop;

    sle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_stat   (q_stat),
        .push     (push),
        .push_grp (push_grp)
    );

    sle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_grp (push_grp),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    sle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_ctrl_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.kind != sle_pkg::K_DATA) |-> out_data.last)
        else $error("end or error result not marked last");

    a_group_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_grp.cnt != 3'd0 && push_grp.cnt <= 3'd4))
        else $error("bad result count");

endmodule

/* sv/sle_front.sv */
module sle_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sle_pkg::in_item_t in_data,
    input  sle_pkg::q_stat_t  q_stat,
    output logic              push,
    output sle_pkg::grp_t     push_grp
);

    sle_pkg::mode_t mode_reg, mode_next;
    logic [7:0]     delim_reg, delim_next;
    logic [20:0]    acc_reg, acc_next;
    logic [1:0]     dcnt_reg, dcnt_next;
    logic [7:0]     prior_reg, prior_next;

    logic accept;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (push_grp.cnt != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= sle_pkg::M_IDLE;
            delim_reg <= 8'd0;
            acc_reg   <= 21'd0;
            dcnt_reg  <= 2'd0;
            prior_reg <= 8'd0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            delim_reg <= delim_next;
            acc_reg   <= acc_next;
            dcnt_reg  <= dcnt_next;
            prior_reg <= prior_next;
        end
    end

    always_comb
    begin
        sle_pkg::grp_t g;
        logic [7:0]    c;
        logic          eof;
        logic [4:0]    hv;
        logic [24:0]   uni_v;
        logic [9:0]    dec_v;
        logic          is_digit;
        logic          do_plain;
        logic          go_idle;

        c        = in_data.in_byte;
        eof      = in_data.end_of_input;
        hv       = eof ? 5'd0 : sle_pkg::hex_val(c);
        uni_v    = {acc_reg, 4'd0} | {21'd0, hv[3:0]};
        dec_v    = {3'd0, acc_reg[6:0]} * 10'd10 + {6'd0, c[3:0]};
        is_digit = !eof && (c >= sle_pkg::CH_0) && (c <= sle_pkg::CH_9);
        g        = '0;
        do_plain = 1'b0;
        go_idle  = 1'b0;

        mode_next  = mode_reg;
        delim_next = delim_reg;
        acc_next   = acc_reg;
        dcnt_next  = dcnt_reg;
        prior_next = prior_reg;

        unique case (mode_reg)
            sle_pkg::M_NORMAL:
                do_plain = 1'b1;
            sle_pkg::M_ESC:
            begin
                if (eof)
                begin
                    g = sle_pkg::grp_put(g, 8'd0, sle_pkg::K_UNFINISHED);
                    go_idle = 1'b1;
                end
                else
                begin
                    mode_next = sle_pkg::M_NORMAL;
                    if (c == sle_pkg::CH_LA)
                        g = sle_pkg::grp_put(g, sle_pkg::CH_BEL, sle_pkg::K_DATA);
                    else if (c == sle_pkg::CH_LB)
                        g = sle_pkg::grp_put(g, sle_pkg::CH_BS, sle_pkg::K_DATA);
                    else if (c == sle_pkg::CH_LF_F)
                        g = sle_pkg::grp_put(g, sle_pkg::CH_FF, sle_pkg::K_DATA);
                    else if (c == sle_pkg::CH_LN)
                        g = sle_pkg::grp_put(g, sle_pkg::CH_LF, sle_pkg::K_DATA);
                    else if (c == sle_pkg::CH_LR)
                        g = sle_pkg::grp_put(g, sle_pkg::CH_CR, sle_pkg::K_DATA);
                    else if (c == sle_pkg::CH_LT)
                        g = sle_pkg::grp_put(g, sle_pkg::CH_TAB, sle_pkg::K_DATA);
                    else if (c == sle_pkg::CH_LV)
                        g = sle_pkg::grp_put(g, sle_pkg::CH_VT, sle_pkg::K_DATA);
                    else if (c == sle_pkg::CH_BSL || c == sle_pkg::CH_DQ
                             || c == sle_pkg::CH_SQ)
                        g = sle_pkg::grp_put(g, c, sle_pkg::K_DATA);
                    else if (c == sle_pkg::CH_LX)
                        mode_next = sle_pkg::M_HEX1;
                    else if (c == sle_pkg::CH_LU)
                        mode_next = sle_pkg::M_UBRACE;
                    else if (c == sle_pkg::CH_LZ)
                        mode_next = sle_pkg::M_ZSKIP;
                    else if (sle_pkg::is_eol(c))
                    begin
                        g = sle_pkg::grp_put(g, sle_pkg::CH_LF, sle_pkg::K_DATA);
                        prior_next = c;
                        mode_next  = sle_pkg::M_EOL;
                    end
                    else if (is_digit)
                    begin
                        acc_next  = {17'd0, c[3:0]};
                        dcnt_next = 2'd1;
                        mode_next = sle_pkg::M_DEC;
                    end
                    else
                    begin
                        g = sle_pkg::grp_put(g, 8'd0, sle_pkg::K_BADESC);
                        go_idle = 1'b1;
                    end
                end
            end
            sle_pkg::M_EOL:
            begin
                prior_next = 8'd0;
                if (!eof && sle_pkg::is_eol(c) && c != prior_reg)
                    mode_next = sle_pkg::M_NORMAL;
                else
                    do_plain = 1'b1;
            end
            sle_pkg::M_HEX1:
            begin
                if (!hv[4])
                begin
                    g = sle_pkg::grp_put(g, 8'd0, sle_pkg::K_BADESC);
                    go_idle = 1'b1;
                end
                else
                begin
                    acc_next  = {17'd0, hv[3:0]};
                    mode_next = sle_pkg::M_HEX2;
                end
            end
            sle_pkg::M_HEX2:
            begin
                if (!hv[4])
                begin
                    g = sle_pkg::grp_put(g, 8'd0, sle_pkg::K_BADESC);
                    go_idle = 1'b1;
                end
                else
                begin
                    g = sle_pkg::grp_put(g, {acc_reg[3:0], hv[3:0]}, sle_pkg::K_DATA);
                    acc_next  = 21'd0;
                    mode_next = sle_pkg::M_NORMAL;
                end
            end
            sle_pkg::M_UBRACE:
            begin
                if (!eof && c == sle_pkg::CH_LBRACE)
                    mode_next = sle_pkg::M_UFIRST;
                else
                begin
                    g = sle_pkg::grp_put(g, 8'd0, sle_pkg::K_BADESC);
                    go_idle = 1'b1;
                end
            end
            sle_pkg::M_UFIRST, sle_pkg::M_UDIGITS:
            begin
                if (mode_reg == sle_pkg::M_UDIGITS && !eof && c == sle_pkg::CH_RBRACE)
                begin
                    if (acc_reg < 21'h80)
                        g = sle_pkg::grp_put(g, acc_reg[7:0], sle_pkg::K_DATA);
                    else if (acc_reg < 21'h800)
                    begin
                        g = sle_pkg::grp_put(g, {3'b110, acc_reg[10:6]}, sle_pkg::K_DATA);
                        g = sle_pkg::grp_put(g, {2'b10, acc_reg[5:0]}, sle_pkg::K_DATA);
                    end
                    else if (acc_reg < 21'h10000)
                    begin
                        if (acc_reg[15:11] == 5'b11011)
                        begin
                            g = sle_pkg::grp_put(g, 8'd0, sle_pkg::K_BADESC);
                            go_idle = 1'b1;
                        end
                        else
                        begin
                            g = sle_pkg::grp_put(g, {4'b1110, acc_reg[15:12]},
                                                 sle_pkg::K_DATA);
                            g = sle_pkg::grp_put(g, {2'b10, acc_reg[11:6]}, sle_pkg::K_DATA);
                            g = sle_pkg::grp_put(g, {2'b10, acc_reg[5:0]}, sle_pkg::K_DATA);
                        end
                    end
                    else
                    begin
                        g = sle_pkg::grp_put(g, {5'b11110, acc_reg[20:18]}, sle_pkg::K_DATA);
                        g = sle_pkg::grp_put(g, {2'b10, acc_reg[17:12]}, sle_pkg::K_DATA);
                        g = sle_pkg::grp_put(g, {2'b10, acc_reg[11:6]}, sle_pkg::K_DATA);
                        g = sle_pkg::grp_put(g, {2'b10, acc_reg[5:0]}, sle_pkg::K_DATA);
                    end
                    if (!go_idle)
                    begin
                        mode_next = sle_pkg::M_NORMAL;
                        acc_next  = 21'd0;
                    end
                end
                else if (!hv[4] || uni_v >= {4'd0, sle_pkg::UNI_LIMIT})
                begin
                    g = sle_pkg::grp_put(g, 8'd0, sle_pkg::K_BADESC);
                    go_idle = 1'b1;
                end
                else
                begin
                    acc_next  = uni_v[20:0];
                    mode_next = sle_pkg::M_UDIGITS;
                end
            end
            sle_pkg::M_ZSKIP:
            begin
                if (eof || !sle_pkg::is_space(c))
                    do_plain = 1'b1;
            end
            sle_pkg::M_DEC:
            begin
                if (is_digit)
                begin
                    if (dcnt_reg >= 2'd2)
                    begin
                        if (dec_v > 10'd255)
                        begin
                            g = sle_pkg::grp_put(g, 8'd0, sle_pkg::K_BADESC);
                            go_idle = 1'b1;
                        end
                        else
                        begin
                            g = sle_pkg::grp_put(g, dec_v[7:0], sle_pkg::K_DATA);
                            acc_next  = 21'd0;
                            dcnt_next = 2'd0;
                            mode_next = sle_pkg::M_NORMAL;
                        end
                    end
                    else
                    begin
                        acc_next  = {11'd0, dec_v};
                        dcnt_next = 2'd2;
                    end
                end
                else
                begin
                    g = sle_pkg::grp_put(g, acc_reg[7:0], sle_pkg::K_DATA);
                    acc_next  = 21'd0;
                    dcnt_next = 2'd0;
                    do_plain  = 1'b1;
                end
            end
            default:
            begin
                go_idle = 1'b1;
                if (!eof)
                    delim_next = c;
            end
        endcase

        // unescaped byte inside the literal
        if (do_plain)
        begin
            mode_next = sle_pkg::M_NORMAL;
            if (!eof && c == delim_reg)
            begin
                g = sle_pkg::grp_put(g, 8'd0, sle_pkg::K_END);
                go_idle = 1'b1;
            end
            else if (eof || sle_pkg::is_eol(c))
            begin
                g = sle_pkg::grp_put(g, 8'd0, sle_pkg::K_UNFINISHED);
                go_idle = 1'b1;
            end
            else if (c == sle_pkg::CH_BSL)
                mode_next = sle_pkg::M_ESC;
            else
                g = sle_pkg::grp_put(g, c, sle_pkg::K_DATA);
        end

        if (go_idle)
        begin
            mode_next  = sle_pkg::M_IDLE;
            acc_next   = 21'd0;
            dcnt_next  = 2'd0;
            prior_next = 8'd0;
        end

        // opening delimiter
        if (mode_reg == sle_pkg::M_IDLE && !eof)
            mode_next = sle_pkg::M_NORMAL;

        push_grp = g;
    end

endmodule

/* sv/sle_queue.sv */
module sle_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sle_pkg::grp_t    push_grp,
    input  logic             pop,
    output sle_pkg::grp_t    head,
    output sle_pkg::q_stat_t q_stat
);

    sle_pkg::grp_t              slot_reg [sle_pkg::QDEPTH];
    logic [sle_pkg::QAW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [sle_pkg::QAW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [sle_pkg::QAW:0]      count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (sle_pkg::QAW+1)'(sle_pkg::QDEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

/* sv/sle_back.sv */
module sle_back (
    input  logic               clk,
    input  logic               rst_n,
    input  sle_pkg::grp_t      head,
    input  sle_pkg::q_stat_t   q_stat,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output sle_pkg::out_item_t out_data
);

    logic               out_valid_reg, out_valid_next;
    sle_pkg::out_item_t out_data_reg, out_data_next;
    logic [1:0]         idx_reg, idx_next;
    logic               load;
    logic               at_last;

    assign load    = !q_stat.empty && (!out_valid_reg || out_ready);
    assign at_last = ({1'b0, idx_reg} == head.cnt - 3'd1);
    assign pop     = load && at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next         = 1'b1;
            out_data_next.out_byte = head.val[idx_reg];
            out_data_next.kind     = sle_pkg::kind_t'(head.knd[idx_reg]);
            out_data_next.last     = at_last;
            idx_next               = at_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* tb/tb_string_literal_escape_decoder.sv */
module tb_string_literal_escape_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    class literal_scoreboard;
        sle_pkg::mode_t     phase;
        logic [7:0]         delim;
        logic [20:0]        accum;
        logic [1:0]         ndigits;
        logic [7:0]         eol_seen;
        sle_pkg::out_item_t burst[$];
        sle_pkg::out_item_t pending[$];
        int                 accepted;
        int                 mismatches;
        int                 kinds_seen[4];

        function new();
            go_idle();
            delim = 8'h00;
            accepted = 0;
            mismatches = 0;
            foreach (kinds_seen[i])
                kinds_seen[i] = 0;
        endfunction

        function void go_idle();
            phase = sle_pkg::M_IDLE;
            accum = '0;
            ndigits = '0;
            eol_seen = '0;
        endfunction

        function void emit(logic [7:0] b, sle_pkg::kind_t k);
            sle_pkg::out_item_t r;
            r.out_byte = b;
            r.kind = k;
            r.last = 1'b0;
            if (burst.size() < 4)
                burst.insert(burst.size(), r);
        endfunction

        function void abort(sle_pkg::kind_t k);
            emit(8'h00, k);
            go_idle();
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= sle_pkg::CH_0 && c <= sle_pkg::CH_9)
                return int'(c) - int'(sle_pkg::CH_0);
            if (c >= "a" && c <= "f")
                return int'(c) - int'("a") + 10;
            if (c >= "A" && c <= "F")
                return int'(c) - int'("A") + 10;
            return -1;
        endfunction

        function bit is_break(logic [7:0] c);
            return c == sle_pkg::CH_LF || c == sle_pkg::CH_CR;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == sle_pkg::CH_SPACE || c == sle_pkg::CH_TAB || c == sle_pkg::CH_LF
                || c == sle_pkg::CH_VT || c == sle_pkg::CH_FF || c == sle_pkg::CH_CR;
        endfunction

        // unescaped byte inside the literal; delimiter test first
        function void plain_byte(logic [7:0] c, logic eof);
            phase = sle_pkg::M_NORMAL;
            if (!eof && c == delim)
            begin
                emit(8'h00, sle_pkg::K_END);
                go_idle();
            end
            else if (eof || is_break(c))
                abort(sle_pkg::K_UNFINISHED);
            else if (c == sle_pkg::CH_BSL)
                phase = sle_pkg::M_ESC;
            else
                emit(c, sle_pkg::K_DATA);
        endfunction

        function void utf8_out(logic [20:0] v);
            if (v < 21'h80)
                emit(v[7:0], sle_pkg::K_DATA);
            else if (v < 21'h800)
            begin
                emit({3'b110, v[10:6]}, sle_pkg::K_DATA);
                emit({2'b10, v[5:0]}, sle_pkg::K_DATA);
            end
            else if (v < 21'h10000)
            begin
                if (v >= 21'hd800 && v < 21'he000)
                begin
                    abort(sle_pkg::K_BADESC);
                    return;
                end
                emit({4'b1110, v[15:12]}, sle_pkg::K_DATA);
                emit({2'b10, v[11:6]}, sle_pkg::K_DATA);
                emit({2'b10, v[5:0]}, sle_pkg::K_DATA);
            end
            else
            begin
                emit({5'b11110, v[20:18]}, sle_pkg::K_DATA);
                emit({2'b10, v[17:12]}, sle_pkg::K_DATA);
                emit({2'b10, v[11:6]}, sle_pkg::K_DATA);
                emit({2'b10, v[5:0]}, sle_pkg::K_DATA);
            end
            phase = sle_pkg::M_NORMAL;
            accum = '0;
        endfunction

        function void unicode_step(logic [7:0] c, logic eof);
            int          h;
            logic [24:0] v;
            h = eof ? -1 : hex_digit(c);
            if (h < 0)
            begin
                abort(sle_pkg::K_BADESC);
                return;
            end
            v = {accum, 4'h0} | {21'd0, h[3:0]};
            if (v >= 25'h110000)
            begin
                abort(sle_pkg::K_BADESC);
                return;
            end
            accum = v[20:0];
            phase = sle_pkg::M_UDIGITS;
        endfunction

        function void escape_byte(logic [7:0] c, logic eof);
            if (eof)
            begin
                abort(sle_pkg::K_UNFINISHED);
                return;
            end
            phase = sle_pkg::M_NORMAL;
            case (c)
                sle_pkg::CH_LA:   emit(sle_pkg::CH_BEL, sle_pkg::K_DATA);
                sle_pkg::CH_LB:   emit(sle_pkg::CH_BS, sle_pkg::K_DATA);
                sle_pkg::CH_LF_F: emit(sle_pkg::CH_FF, sle_pkg::K_DATA);
                sle_pkg::CH_LN:   emit(sle_pkg::CH_LF, sle_pkg::K_DATA);
                sle_pkg::CH_LR:   emit(sle_pkg::CH_CR, sle_pkg::K_DATA);
                sle_pkg::CH_LT:   emit(sle_pkg::CH_TAB, sle_pkg::K_DATA);
                sle_pkg::CH_LV:   emit(sle_pkg::CH_VT, sle_pkg::K_DATA);
                sle_pkg::CH_BSL, sle_pkg::CH_DQ, sle_pkg::CH_SQ: emit(c, sle_pkg::K_DATA);
                sle_pkg::CH_LX:   phase = sle_pkg::M_HEX1;
                sle_pkg::CH_LU:   phase = sle_pkg::M_UBRACE;
                sle_pkg::CH_LZ:   phase = sle_pkg::M_ZSKIP;
                sle_pkg::CH_LF, sle_pkg::CH_CR:
                begin
                    emit(sle_pkg::CH_LF, sle_pkg::K_DATA);
                    eol_seen = c;
                    phase = sle_pkg::M_EOL;
                end
                default:
                begin
                    if (c >= sle_pkg::CH_0 && c <= sle_pkg::CH_9)
                    begin
                        accum = {13'd0, c - sle_pkg::CH_0};
                        ndigits = 2'd1;
                        phase = sle_pkg::M_DEC;
                    end
                    else
                        abort(sle_pkg::K_BADESC);
                end
            endcase
        endfunction

        function void take_source_byte(sle_pkg::in_item_t it);
            logic [7:0] c;
            logic       eof;
            int         h;
            int         dv;
            c = it.in_byte;
            eof = it.end_of_input;
            burst.delete();
            case (phase)
                sle_pkg::M_NORMAL: plain_byte(c, eof);
                sle_pkg::M_ESC:    escape_byte(c, eof);
                sle_pkg::M_EOL:
                begin
                    if (!eof && is_break(c) && c != eol_seen)
                    begin
                        eol_seen = '0;
                        phase = sle_pkg::M_NORMAL;
                    end
                    else
                    begin
                        eol_seen = '0;
                        plain_byte(c, eof);
                    end
                end
                sle_pkg::M_HEX1:
                begin
                    h = eof ? -1 : hex_digit(c);
                    if (h < 0)
                        abort(sle_pkg::K_BADESC);
                    else
                    begin
                        accum = h[20:0];
                        phase = sle_pkg::M_HEX2;
                    end
                end
                sle_pkg::M_HEX2:
                begin
                    h = eof ? -1 : hex_digit(c);
                    if (h < 0)
                        abort(sle_pkg::K_BADESC);
                    else
                    begin
                        emit({accum[3:0], h[3:0]}, sle_pkg::K_DATA);
                        accum = '0;
                        phase = sle_pkg::M_NORMAL;
                    end
                end
                sle_pkg::M_UBRACE:
                begin
                    if (!eof && c == sle_pkg::CH_LBRACE)
                        phase = sle_pkg::M_UFIRST;
                    else
                        abort(sle_pkg::K_BADESC);
                end
                sle_pkg::M_UFIRST: unicode_step(c, eof);
                sle_pkg::M_UDIGITS:
                begin
                    if (!eof && c == sle_pkg::CH_RBRACE)
                        utf8_out(accum);
                    else
                        unicode_step(c, eof);
                end
                sle_pkg::M_ZSKIP:
                begin
                    if (eof || !is_blank(c))
                        plain_byte(c, eof);
                end
                sle_pkg::M_DEC:
                begin
                    if (!eof && c >= sle_pkg::CH_0 && c <= sle_pkg::CH_9)
                    begin
                        dv = int'(accum) * 10 + (int'(c) - int'(sle_pkg::CH_0));
                        if (ndigits >= 2'd2)
                        begin
                            if (dv > 255)
                                abort(sle_pkg::K_BADESC);
                            else
                            begin
                                emit(dv[7:0], sle_pkg::K_DATA);
                                accum = '0;
                                ndigits = '0;
                                phase = sle_pkg::M_NORMAL;
                            end
                        end
                        else
                        begin
                            accum = dv[20:0];
                            ndigits = 2'd2;
                        end
                    end
                    else
                    begin
                        emit(accum[7:0], sle_pkg::K_DATA);
                        accum = '0;
                        ndigits = '0;
                        plain_byte(c, eof);
                    end
                end
                default:
                begin
                    go_idle();
                    if (!eof)
                    begin
                        delim = c;
                        phase = sle_pkg::M_NORMAL;
                    end
                end
            endcase
            if (burst.size() > 0)
                burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i])
                pending.insert(pending.size(), burst[i]);
            accepted++;
        endfunction

        function void check_decoded(sle_pkg::out_item_t got);
            sle_pkg::out_item_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected item: out_byte %0h kind %0d last %0d",
                       got.out_byte, got.kind, got.last);
                mismatches++;
                return;
            end
            want = pending[0];
            pending.delete(0);
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
            kinds_seen[want.kind]++;
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    sle_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    sle_pkg::out_item_t out_data;

    literal_scoreboard sb = new();

    int sender_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int cycle_count = 0;

    string_literal_escape_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending.size());
        $display("tb_string_literal_escape_decoder NOT OK");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_decoded(out_data);
    end

    // entered and left just after a falling edge
    task automatic offer(logic [7:0] b, logic eof);
        sle_pkg::in_item_t it;
        it.in_byte = b;
        it.end_of_input = eof;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.take_source_byte(it);
        @(negedge clk);
    endtask

    task automatic offer_text(string s);
        for (int i = 0; i < s.len(); i++)
            offer(s[i], 1'b0);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return sle_pkg::CH_0 + n;
        if ($urandom_range(1))
            return 8'("a" + n - 10);
        return 8'("A" + n - 10);
    endfunction

    task automatic send_hex_digits(logic [23:0] v, int zeros);
        int n;
        n = 1;
        while (n < 6 && (v >> (4 * n)) != 0)
            n++;
        repeat (zeros) offer(sle_pkg::CH_0, 1'b0);
        for (int i = n - 1; i >= 0; i--)
            offer(hex_char(v[4 * i +: 4]), 1'b0);
    endtask

    task automatic send_decimal(int v, bit full);
        if (full || v >= 100)
            offer(8'(sle_pkg::CH_0 + v / 100), 1'b0);
        if (full || v >= 10)
            offer(8'(sle_pkg::CH_0 + (v / 10) % 10), 1'b0);
        offer(8'(sle_pkg::CH_0 + v % 10), 1'b0);
    endtask

    task automatic send_plain(logic [7:0] d);
        logic [7:0] b;
        do
            b = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                         : 8'($urandom_range(32, 126));
        while (b == d || b == sle_pkg::CH_BSL || b == sle_pkg::CH_LF
               || b == sle_pkg::CH_CR);
        offer(b, 1'b0);
    endtask

    task automatic send_escape_piece();
        logic [23:0] v;
        logic [7:0]  b;
        offer(sle_pkg::CH_BSL, 1'b0);
        case ($urandom_range(5))
            0:
            begin
                case ($urandom_range(9))
                    0: b = sle_pkg::CH_LA;
                    1: b = sle_pkg::CH_LB;
                    2: b = sle_pkg::CH_LF_F;
                    3: b = sle_pkg::CH_LN;
                    4: b = sle_pkg::CH_LR;
                    5: b = sle_pkg::CH_LT;
                    6: b = sle_pkg::CH_LV;
                    7: b = sle_pkg::CH_BSL;
                    8: b = sle_pkg::CH_DQ;
                    default: b = sle_pkg::CH_SQ;
                endcase
                offer(b, 1'b0);
            end
            1:
            begin
                v = 24'($urandom_range(255));
                offer(sle_pkg::CH_LX, 1'b0);
                offer(hex_char(v[7:4]), 1'b0);
                offer(hex_char(v[3:0]), 1'b0);
            end
            2:
            begin
                case ($urandom_range(4))
                    0: v = 24'($urandom_range(24'h7f));
                    1: v = 24'($urandom_range(24'h80, 24'h7ff));
                    2: do v = 24'($urandom_range(24'h800, 24'hffff));
                       while (v >= 24'hd800 && v < 24'he000);
                    3: v = 24'($urandom_range(24'h10000, 24'h10ffff));
                    default:
                    begin
                        case ($urandom_range(9))
                            0: v = 24'h0;
                            1: v = 24'h7f;
                            2: v = 24'h80;
                            3: v = 24'h7ff;
                            4: v = 24'h800;
                            5: v = 24'hd7ff;
                            6: v = 24'he000;
                            7: v = 24'hffff;
                            8: v = 24'h10000;
                            default: v = 24'h10ffff;
                        endcase
                    end
                endcase
                offer(sle_pkg::CH_LU, 1'b0);
                offer(sle_pkg::CH_LBRACE, 1'b0);
                send_hex_digits(v, $urandom_range(2));
                offer(sle_pkg::CH_RBRACE, 1'b0);
            end
            3: send_decimal($urandom_range(255), $urandom_range(1));
            4:
            begin
                offer(sle_pkg::CH_LZ, 1'b0);
                repeat ($urandom_range(4))
                begin
                    case ($urandom_range(5))
                        0: b = sle_pkg::CH_SPACE;
                        1: b = sle_pkg::CH_TAB;
                        2: b = sle_pkg::CH_LF;
                        3: b = sle_pkg::CH_VT;
                        4: b = sle_pkg::CH_FF;
                        default: b = sle_pkg::CH_CR;
                    endcase
                    offer(b, 1'b0);
                end
            end
            default:
            begin
                b = $urandom_range(1) ? sle_pkg::CH_LF : sle_pkg::CH_CR;
                offer(b, 1'b0);
                if ($urandom_range(1))
                    offer(b == sle_pkg::CH_LF ? sle_pkg::CH_CR : sle_pkg::CH_LF, 1'b0);
            end
        endcase
    endtask

    // usually leaves the decoder idle, or with an escape that end of input closes
    task automatic send_broken_escape();
        logic [23:0] v;
        offer(sle_pkg::CH_BSL, 1'b0);
        case ($urandom_range(7))
            0: offer(8'($urandom_range(255)), 1'b0);
            1:
            begin
                offer(sle_pkg::CH_LX, 1'b0);
                offer(hex_char(4'($urandom_range(15))), 1'b0);
                offer("g", 1'b0);
            end
            2:
            begin
                offer(sle_pkg::CH_LU, 1'b0);
                offer("(", 1'b0);
            end
            3:
            begin
                offer(sle_pkg::CH_LU, 1'b0);
                offer(sle_pkg::CH_LBRACE, 1'b0);
                offer(sle_pkg::CH_RBRACE, 1'b0);
            end
            4:
            begin
                offer(sle_pkg::CH_LU, 1'b0);
                offer(sle_pkg::CH_LBRACE, 1'b0);
                v = 24'($urandom_range(24'h110000, 24'hffffff));
                send_hex_digits(v, $urandom_range(2));
            end
            5:
            begin
                offer(sle_pkg::CH_LU, 1'b0);
                offer(sle_pkg::CH_LBRACE, 1'b0);
                v = 24'($urandom_range(24'hd800, 24'hdfff));
                send_hex_digits(v, $urandom_range(1));
                offer(sle_pkg::CH_RBRACE, 1'b0);
            end
            6: send_decimal($urandom_range(256, 999), 1'b1);
            default:
            begin
                case ($urandom_range(9))
                    0: ;
                    1: offer(sle_pkg::CH_LX, 1'b0);
                    2:
                    begin
                        offer(sle_pkg::CH_LX, 1'b0);
                        offer(hex_char(4'($urandom_range(15))), 1'b0);
                    end
                    3: offer(sle_pkg::CH_LU, 1'b0);
                    4:
                    begin
                        offer(sle_pkg::CH_LU, 1'b0);
                        offer(sle_pkg::CH_LBRACE, 1'b0);
                    end
                    5:
                    begin
                        offer(sle_pkg::CH_LU, 1'b0);
                        offer(sle_pkg::CH_LBRACE, 1'b0);
                        offer(hex_char(4'($urandom_range(15))), 1'b0);
                    end
                    6:
                    begin
                        offer(sle_pkg::CH_LZ, 1'b0);
                        offer(sle_pkg::CH_SPACE, 1'b0);
                    end
                    7: offer(sle_pkg::CH_LF, 1'b0);
                    8: offer(8'(sle_pkg::CH_0 + $urandom_range(9)), 1'b0);
                    default:
                    begin
                        offer(8'(sle_pkg::CH_0 + $urandom_range(9)), 1'b0);
                        offer(8'(sle_pkg::CH_0 + $urandom_range(9)), 1'b0);
                    end
                endcase
                offer(8'($urandom_range(255)), 1'b1);
            end
        endcase
    endtask

    task automatic send_literal();
        logic [7:0] d;
        int         r;
        r = $urandom_range(99);
        d = (r < 45) ? sle_pkg::CH_DQ : (r < 80) ? sle_pkg::CH_SQ : 8'($urandom_range(255));
        offer(d, 1'b0);
        repeat ($urandom_range(8))
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                send_broken_escape();
                return;
            end
            if (r < 50)
                send_plain(d);
            else
                send_escape_piece();
        end
        r = $urandom_range(99);
        if (r < 82)
            offer(d, 1'b0);
        else if (r < 90)
            offer(8'($urandom_range(255)), 1'b1);
        else if (r < 96)
            offer($urandom_range(1) ? sle_pkg::CH_LF : sle_pkg::CH_CR, 1'b0);
        else
            offer(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic run_phase(int idle_pct, int hold_pct, int upto);
        sender_idle_pct = idle_pct;
        stall_pct = hold_pct;
        while (sb.accepted < upto)
            send_literal();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // end of input while idle, then an all-ones delimiter around extremes
        offer(8'h00, 1'b1);
        offer(8'hff, 1'b0);
        offer(8'h00, 1'b0);
        offer_text("\\u{10FFFF}");
        offer_text("\\255");
        offer_text("\\7q");
        offer(8'hff, 1'b0);
        offer(sle_pkg::CH_DQ, 1'b0);
        offer(8'hff, 1'b1);

        run_phase(0, 0, 80);
        run_phase(65, 0, 140);
        run_phase(0, 65, 200);
        run_phase(8, 8, 240);
        hold_left = 250;
        run_phase(0, 0, 265);

        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d source items decoded into %0d data bytes and %0d string ends",
                 sb.accepted, sb.kinds_seen[sle_pkg::K_DATA], sb.kinds_seen[sle_pkg::K_END]);
        $display("errors seen: %0d bad escape, %0d unfinished; %0d mismatches",
                 sb.kinds_seen[sle_pkg::K_BADESC], sb.kinds_seen[sle_pkg::K_UNFINISHED],
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb_string_literal_escape_decoder OK");
        else
            $display("tb_string_literal_escape_decoder NOT OK");
        $finish;
    end

endmodule
